[hw/rtl/bole_pkg.sv]
// Shared types and constants for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int MODE_W  = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 3;
  localparam int LEN_W   = 5;
  localparam int TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_END   = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_END   = 3'd4,
    MODE_DEL_VAL   = 3'd5,
    MODE_REVERSE   = 3'd6,
    MODE_READ      = 3'd7
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL,
    ACT_FLIP
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/bole_ctrl.sv]
// Controller state machine for the bounded ordered list engine.
`default_nettype none

module bole_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire bole_pkg::sts_t sts,
  output bole_pkg::cmd_t     cmd
);

  bole_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      bole_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = sts.need_scan ? bole_pkg::S_SCAN : bole_pkg::S_FINISH;
        end
      end
      bole_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = bole_pkg::S_FINISH;
        end
      end
      bole_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = bole_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bole_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bole_datapath.sv]
// Datapath of the bounded ordered list engine: value cells, length, orientation, result register.
`default_nettype none

module bole_datapath #(
  parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [bole_pkg::TDATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [bole_pkg::TDATA_W-1:0]     m_tdata,
  input  wire bole_pkg::cmd_t              cmd,
  output bole_pkg::sts_t                   sts
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > bole_pkg::POS_W) ? LW : bole_pkg::POS_W) + 1;

  // Cells hold the list in physical order; rev means the logical order runs
  // from the highest occupied cell down to cell zero, so reversing is a flip.
  logic [bole_pkg::VAL_W-1:0] cells [DEPTH];
  logic [LW-1:0]              len;
  logic                       rev;

  bole_pkg::mode_t            op_mode;
  logic [bole_pkg::VAL_W-1:0] op_value;
  logic [bole_pkg::POS_W-1:0] op_pos;
  logic [IW-1:0]              cnt;
  logic                       found;
  logic [IW-1:0]              found_idx;

  logic [CW-1:0]              len_c, pos_c, cnt_c, scan_phys_c, k_c, len_next_c;
  logic [IW-1:0]              rd_idx;
  logic [bole_pkg::VAL_W-1:0] rd_data;
  logic                       hit;
  logic                       empty;
  bole_pkg::status_t          status;
  bole_pkg::action_t          act;
  logic [bole_pkg::VAL_W-1:0] res;

  assign len_c       = CW'(len);
  assign pos_c       = CW'(op_pos);
  assign cnt_c       = CW'(cnt);
  assign empty       = (len == '0);
  assign scan_phys_c = rev ? (len_c - CW'(1) - cnt_c) : cnt_c;

  // One read port, shared by the scan and the final operation.
  assign rd_idx  = cmd.scan ? scan_phys_c[IW-1:0] : k_c[IW-1:0];
  assign rd_data = cells[rd_idx];
  assign hit     = (rd_data == op_value);

  assign sts.need_scan = (bole_pkg::mode_t'(s_tdata[bole_pkg::MODE_W-1:0])
                          == bole_pkg::MODE_DEL_VAL);
  assign sts.scan_done = empty || hit || (cnt_c == len_c - CW'(1));
  assign sts.out_free  = !m_tvalid || m_tready;

  always_comb begin
    logic [CW-1:0] at;
    at     = '0;
    status = bole_pkg::ST_OK;
    act    = bole_pkg::ACT_NONE;
    k_c    = '0;
    res    = '0;
    case (op_mode)
      bole_pkg::MODE_INS_FRONT, bole_pkg::MODE_INS_END, bole_pkg::MODE_INS_POS: begin
        case (op_mode)
          bole_pkg::MODE_INS_FRONT: at = '0;
          bole_pkg::MODE_INS_END:   at = len_c;
          default:                  at = pos_c - CW'(1);
        endcase
        k_c = rev ? (len_c - at) : at;
        if (op_mode == bole_pkg::MODE_INS_POS &&
            (pos_c == '0 || pos_c > len_c + CW'(1))) begin
          status = bole_pkg::ST_BADPOS;
        end else if (len_c >= CW'(DEPTH)) begin
          status = bole_pkg::ST_FULL;
        end else begin
          act = bole_pkg::ACT_INS;
        end
      end
      bole_pkg::MODE_DEL_FRONT, bole_pkg::MODE_DEL_END: begin
        if ((op_mode == bole_pkg::MODE_DEL_FRONT) == rev) begin
          k_c = len_c - CW'(1);
        end else begin
          k_c = '0;
        end
        if (empty) begin
          status = bole_pkg::ST_EMPTY;
        end else begin
          act = bole_pkg::ACT_DEL;
          res = rd_data;
        end
      end
      bole_pkg::MODE_DEL_VAL: begin
        k_c = CW'(found_idx);
        if (empty) begin
          status = bole_pkg::ST_EMPTY;
        end else if (!found) begin
          status = bole_pkg::ST_NOTFOUND;
        end else begin
          act = bole_pkg::ACT_DEL;
          res = op_value;
        end
      end
      bole_pkg::MODE_REVERSE: begin
        act = bole_pkg::ACT_FLIP;
      end
      default: begin
        k_c = rev ? (len_c - pos_c) : (pos_c - CW'(1));
        if (empty) begin
          status = bole_pkg::ST_EMPTY;
        end else if (pos_c == '0 || pos_c > len_c) begin
          status = bole_pkg::ST_BADPOS;
        end else begin
          res = rd_data;
        end
      end
    endcase
  end

  always_comb begin
    case (act)
      bole_pkg::ACT_INS: len_next_c = len_c + CW'(1);
      bole_pkg::ACT_DEL: len_next_c = len_c - CW'(1);
      default:           len_next_c = len_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      rev      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
        len      <= len_next_c[LW-1:0];
        if (act == bole_pkg::ACT_FLIP) begin
          rev <= ~rev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_mode  <= bole_pkg::mode_t'(s_tdata[bole_pkg::MODE_W-1:0]);
      op_value <= s_tdata[bole_pkg::MODE_W +: bole_pkg::VAL_W];
      op_pos   <= s_tdata[bole_pkg::MODE_W + bole_pkg::VAL_W +: bole_pkg::POS_W];
      cnt      <= '0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      cnt <= cnt + IW'(1);
      if (hit && !empty) begin
        found     <= 1'b1;
        found_idx <= rd_idx;
      end
    end
    if (cmd.commit) begin
      m_tdata <= {len_next_c[bole_pkg::LEN_W-1:0], res, status};
    end
  end

  // Each cell takes its lower or upper neighbor when a gap opens or closes.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        case (act)
          bole_pkg::ACT_INS: begin
            if (CW'(i) == k_c) begin
              cells[i] <= op_value;
            end else if (i > 0 && CW'(i) > k_c) begin
              cells[i] <= cells[(i > 0) ? i - 1 : 0];
            end
          end
          bole_pkg::ACT_DEL: begin
            if (i < DEPTH - 1 && CW'(i) >= k_c) begin
              cells[i] <= cells[(i < DEPTH - 1) ? i + 1 : i];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   tvalid / tready    mode, value, position
//   m_*      out  tvalid / tready    status, out_value, length
//
// Every operation except delete-by-value is accepted, then finished.
// Delete-by-value scans the list one cell per cycle through the single cell
// read port up to the first match or the last cell, between accept and
// finish; it passes through the scan state even when the list is empty.
// Input is taken only while the controller is idle; a finished result waits in
// the output register while the next item is accepted.
// The finish cycle stalls while the output register still holds an untaken result.
// Reset clears the length, the orientation flag and the output valid; cells are not reset.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // mode[2:0], value[34:3], position[39:35]
  input  wire logic [bole_pkg::TDATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // status[2:0], out_value[34:3], length[39:35]
  output logic [bole_pkg::TDATA_W-1:0]      m_tdata
);

  bole_pkg::cmd_t cmd;
  bole_pkg::sts_t sts;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bole_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

[hw/rtl/bole_checker.sv]
// Port-level assertions for the bounded ordered list engine, bound to the top level.
`default_nettype none

module bole_checker #(
  parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [bole_pkg::TDATA_W-1:0] m_tdata
);

  logic [bole_pkg::STAT_W-1:0] stat;
  logic [bole_pkg::VAL_W-1:0]  oval;
  logic [bole_pkg::LEN_W-1:0]  olen;

  assign stat = m_tdata[bole_pkg::STAT_W-1:0];
  assign oval = m_tdata[bole_pkg::STAT_W +: bole_pkg::VAL_W];
  assign olen = m_tdata[bole_pkg::STAT_W + bole_pkg::VAL_W +: bole_pkg::LEN_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat != bole_pkg::ST_OK |-> oval == '0)
    else $error("failed operation returned a value");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat == bole_pkg::ST_EMPTY |-> olen == '0)
    else $error("empty status with nonzero length");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stat == bole_pkg::ST_FULL && DEPTH < 32
      |-> olen == bole_pkg::LEN_W'(DEPTH))
    else $error("full status with wrong length");

endmodule

bind bounded_ordered_list_engine bole_checker #(.DEPTH(DEPTH)) u_bole_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered list engine.
module testbench;
  import bole_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    status_t     status;
    logic [31:0] out_value;
    logic [4:0]  length;
  } list_result_t;

  // Mirrors the list contents and holds the results still owed by the block.
  class list_mirror;
    logic [31:0]  cells [DEPTH];
    int           count;
    int           mismatches;
    list_result_t expected_results [$];

    function logic [31:0] take(int at);
      logic [31:0] v;
      int i;
      v = cells[at];
      for (i = at; i + 1 < count; i++) cells[i] = cells[i + 1];
      count--;
      return v;
    endfunction

    function void apply_op(mode_t m, logic [31:0] v, logic [4:0] p);
      list_result_t r;
      int at;
      int i;
      int hit;
      logic [31:0] t;
      r.status = ST_OK;
      r.out_value = '0;
      hit = -1;
      case (m)
        MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
          at = (m == MODE_INS_FRONT) ? 0 : (m == MODE_INS_END) ? count : int'(p) - 1;
          // A bad position wins over a full list.
          if (m == MODE_INS_POS && (p == 0 || p > count + 1)) begin
            r.status = ST_BADPOS;
          end else if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > at; i--) cells[i] = cells[i - 1];
            cells[at] = v;
            count++;
          end
        end
        MODE_DEL_FRONT: begin
          if (count == 0) r.status = ST_EMPTY;
          else r.out_value = take(0);
        end
        MODE_DEL_END: begin
          if (count == 0) r.status = ST_EMPTY;
          else r.out_value = take(count - 1);
        end
        MODE_DEL_VAL: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (i = count - 1; i >= 0; i--) if (cells[i] == v) hit = i;
            if (hit < 0) r.status = ST_NOTFOUND;
            else r.out_value = take(hit);
          end
        end
        MODE_REVERSE: begin
          for (i = 0; 2 * i + 1 < count; i++) begin
            t = cells[i];
            cells[i] = cells[count - 1 - i];
            cells[count - 1 - i] = t;
          end
        end
        default: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (p == 0 || p > count) r.status = ST_BADPOS;
          else r.out_value = cells[p - 1];
        end
      endcase
      r.length = 5'(count);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [TDATA_W-1:0] d);
      list_result_t e;
      if (expected_results.size() == 0) begin
        $error("result %h arrived with nothing expected", d);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (d[2:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[2:0]);
        mismatches++;
      end
      if (d[34:3] !== e.out_value) begin
        $error("out_value: expected %0d, got %0d", $signed(e.out_value), $signed(d[34:3]));
        mismatches++;
      end
      if (d[39:35] !== e.length) begin
        $error("length: expected %0d, got %0d", e.length, d[39:35]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;

  int         send_idle = 31;
  int         recv_idle = 45;
  logic       hold_req = 1'b0;
  list_mirror mirror = new();

  bounded_ordered_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one transaction after a random gap and returns at the edge that takes it.
  task automatic send_item(input mode_t m, input logic [31:0] v, input logic [4:0] p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, v, m};
    do @(posedge clk); while (!s_tready);
    mirror.apply_op(m, v, p);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  // Blocks of 50 lean toward inserts, then deletes, then neither, so the list
  // swings between full and empty.
  task automatic run_random(input int n);
    int k;
    int r;
    int ins_pct;
    int del_pct;
    mode_t m;
    logic [31:0] v;
    logic [4:0] p;
    for (k = 0; k < n; k++) begin
      case ((k / 50) % 3)
        0:       begin ins_pct = 60; del_pct = 20; end
        1:       begin ins_pct = 20; del_pct = 60; end
        default: begin ins_pct = 35; del_pct = 35; end
      endcase
      r = $urandom_range(99);
      if (r < ins_pct) m = mode_t'($urandom_range(0, 2));
      else if (r < ins_pct + del_pct) m = mode_t'($urandom_range(3, 5));
      else m = mode_t'($urandom_range(6, 7));
      case ($urandom_range(9))
        0, 1, 2, 3: v = (mirror.count > 0) ? mirror.cells[$urandom_range(0, mirror.count - 1)]
                                           : $urandom();
        4:          v = 32'h8000_0000;
        5:          v = 32'h7fff_ffff;
        6:          v = $urandom_range(0, 3);
        default:    v = $urandom();
      endcase
      if ($urandom_range(9) < 7) p = 5'($urandom_range(1, mirror.count + 1));
      else p = 5'($urandom_range(0, 17));
      send_item(m, v, p);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list corner cases.
    send_item(MODE_READ,      32'd0,          5'd1);
    send_item(MODE_DEL_FRONT, 32'd0,          5'd0);
    send_item(MODE_DEL_END,   32'd0,          5'd0);
    send_item(MODE_DEL_VAL,   32'd0,          5'd0);
    send_item(MODE_REVERSE,   32'd0,          5'd0);
    send_item(MODE_INS_POS,   32'd5,          5'd0);
    send_item(MODE_INS_POS,   32'd5,          5'd2);
    // Build a short list with extreme values and check its order.
    send_item(MODE_INS_POS,   32'h7fff_ffff,  5'd1);
    send_item(MODE_REVERSE,   32'd0,          5'd0);
    send_item(MODE_INS_FRONT, 32'h8000_0000,  5'd0);
    send_item(MODE_INS_END,   32'd0,          5'd0);
    send_item(MODE_INS_POS,   32'hffff_ffff,  5'd4);
    send_item(MODE_INS_POS,   32'h5555_5555,  5'd2);
    send_item(MODE_READ,      32'd0,          5'd0);
    send_item(MODE_READ,      32'd0,          5'd5);
    send_item(MODE_READ,      32'd0,          5'd6);
    send_item(MODE_READ,      32'd0,          5'd17);
    send_item(MODE_REVERSE,   32'd0,          5'd0);
    send_item(MODE_READ,      32'd0,          5'd1);
    send_item(MODE_DEL_VAL,   32'haaaa_aaaa,  5'd0);
    send_item(MODE_DEL_VAL,   32'd0,          5'd0);
    send_item(MODE_DEL_FRONT, 32'd0,          5'd0);
    send_item(MODE_DEL_END,   32'd0,          5'd0);
    send_item(MODE_INS_POS,   32'd9,          5'd16);
    send_item(MODE_DEL_VAL,   32'h5555_5555,  5'd0);

    // The receiver holds off at the start of the random part to back up the block.
    hold_req <= 1'b1;
    run_random(250);
    wait_drained();
    send_idle = 45;
    recv_idle = 31;
    run_random(250);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    run_random(250);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_result(m_tdata);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
